// File: design/qdd_pkg.sv
// qdd_pkg: shared types and constants for the quadrature detent decoder.
// No dependencies.
package qdd_pkg;

  localparam int TimeBits = 32;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [1:0]          pair_t;
  typedef logic signed [1:0]   step_t;
  typedef logic signed [4:0]   accum_t;

  typedef enum logic [1:0] {
    REG_DETENT_STEPS    = 2'd0,
    REG_MIN_GAP_MS      = 2'd1,
    REG_REVERSAL_GAP_MS = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

  localparam logic [4:0] DetentReset   = 5'd4;
  localparam logic [7:0] MinGapReset   = 8'd1;
  localparam logic [7:0] RevGapReset   = 8'd6;
  localparam logic [4:0] DetentMax     = 5'd16;

  localparam step_t StepNone = 2'sb00;
  localparam step_t StepCw   = 2'sb01;
  localparam step_t StepCcw  = 2'sb11;

  // Gray order 00 -> 01 -> 11 -> 10 -> 00 is clockwise.
  function automatic logic is_cw(pair_t prev, pair_t cur);
    logic r;
    r = ((prev == 2'b00) && (cur == 2'b01)) || ((prev == 2'b01) && (cur == 2'b11)) ||
        ((prev == 2'b11) && (cur == 2'b10)) || ((prev == 2'b10) && (cur == 2'b00));
    return r;
  endfunction

endpackage

// File: design/quadrature_detent_decoder_core.sv
// quadrature_detent_decoder_core: quadrature A/B sample decoder with time filters
// and detent accumulation. Depends on qdd_pkg.

// One sample in, one click result out, in order. A sample is captured in an
// input register, evaluated combinationally against the stored pair,
// accumulator and last accepted timestamp, and the result lands in an output
// register once the output side can take it; a new sample is taken every cycle
// while the output side keeps up (the state update is a single registered pass,
// so throughput is one item per clock). Configuration writes take effect at the
// next clock and must be issued while the block is idle.
module quadrature_detent_decoder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_line_a,
  input  logic                 in_line_b,
  input  qdd_pkg::time_t       in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qdd_pkg::step_t       out_step,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);
  import qdd_pkg::*;

  logic       detent_ok;
  logic [4:0] detent_r;
  logic [7:0] min_gap_r;
  logic [7:0] rev_gap_r;

  logic  in_vld_r;
  pair_t in_pair_r;
  time_t in_now_r;

  pair_t  pair_r,  pair_nxt;
  accum_t accum_r, accum_nxt;
  time_t  last_t_r, last_t_nxt;

  logic  out_vld_r;
  step_t out_step_r, out_step_nxt;

  logic              adv;
  logic              cw;
  logic signed [5:0] delta;
  logic signed [5:0] sum;
  logic [5:0]        mag;
  logic [4:0]        limit;
  time_t             elapsed;
  logic              reversal;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detent_r  <= DetentReset;
      min_gap_r <= MinGapReset;
      rev_gap_r <= RevGapReset;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DETENT_STEPS:    detent_r  <= cfg_wdata[4:0];
        REG_MIN_GAP_MS:      min_gap_r <= cfg_wdata;
        REG_REVERSAL_GAP_MS: rev_gap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_pair_r <= {in_line_a, in_line_b};
      in_now_r  <= in_now_ms;
    end
  end

  // decode
  assign detent_ok = (detent_r <= DetentMax);
  assign limit     = detent_ok ? detent_r : DetentMax;
  assign cw        = is_cw(pair_r, in_pair_r);
  assign delta     = cw ? 6'sd1 : -6'sd1;
  assign sum       = {accum_r[4], accum_r} + delta;
  assign mag       = sum[5] ? 6'(-sum) : 6'(sum);
  assign elapsed   = in_now_r - last_t_r;
  assign reversal  = ((accum_r > 5'sd0) && !cw) || ((accum_r < 5'sd0) && cw);

  always_comb begin
    pair_nxt     = pair_r;
    accum_nxt    = accum_r;
    last_t_nxt   = last_t_r;
    out_step_nxt = StepNone;
    if (in_pair_r != pair_r) begin
      pair_nxt = in_pair_r;
      if ((in_pair_r ^ pair_r) != 2'b11) begin
        if (elapsed < time_t'(min_gap_r)) begin
          out_step_nxt = StepNone;
        end else if ((elapsed < time_t'(rev_gap_r)) && reversal) begin
          out_step_nxt = StepNone;
        end else begin
          last_t_nxt = in_now_r;
          if (mag >= {1'b0, limit}) begin
            out_step_nxt = (sum > 6'sd0) ? StepCw : StepCcw;
            accum_nxt    = '0;
          end else begin
            accum_nxt = sum[4:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r   <= '0;
      accum_r  <= '0;
      last_t_r <= '0;
    end else if (adv) begin
      pair_r   <= pair_nxt;
      accum_r  <= accum_nxt;
      last_t_r <= last_t_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_step_r <= out_step_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_step  = out_step_r;

  a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
    accum_r != 5'sb10000)
    else $error("accumulator reached -16");

  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_step_r != 2'sb10))
    else $error("illegal step code");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(accum_r) && $stable(pair_r) && $stable(last_t_r)))
    else $error("state changed without a transaction");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input stalled while input stage empty");

  a_no_click_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (in_pair_r == pair_r)) |=> (out_step_r == StepNone))
    else $error("click on unchanged pair");

endmodule

// File: dv/quadrature_detent_decoder_core_test.sv
// Testbench for quadrature_detent_decoder_core: A/B samples with timestamps go in,
// and an in-file predictor checks every step result in order.
// Depends on qdd_pkg and the core module; needs nothing else.
`timescale 1ns / 100ps

module quadrature_detent_decoder_core_test;
  import qdd_pkg::*;

  localparam int IdleMax       = 18;
  localparam int HoldCycles    = 64;
  localparam int DrainCycles   = 4;
  localparam int WatchdogLimit = 1000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  logic     in_line_a = 1'b0;
  logic     in_line_b = 1'b0;
  time_t    in_now_ms = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  step_t    out_step;
  logic     cfg_we    = 1'b0;
  reg_idx_t cfg_index = REG_DETENT_STEPS;
  logic [7:0] cfg_wdata = '0;

  // predictor state and its copy of the registers
  pair_t      pred_pair    = 2'b00;
  int         pred_accum   = 0;
  time_t      pred_stamp   = '0;
  logic [4:0] pred_detent  = DetentReset;
  logic [7:0] pred_min_gap = MinGapReset;
  logic [7:0] pred_rev_gap = RevGapReset;

  step_t expected_clicks[$];

  pair_t tb_pair  = 2'b00;
  time_t tb_stamp = '0;
  logic  tx_idle_on  = 1'b1;
  logic  rx_idle_on  = 1'b1;
  logic  rx_hold_req = 1'b0;

  int errors             = 0;
  int samples_sent       = 0;
  int clicks_cw          = 0;
  int clicks_ccw         = 0;
  int input_stall_cycles = 0;
  int settings_used      = 1;
  int quiet_cycles       = 0;

  quadrature_detent_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_line_a (in_line_a),
    .in_line_b (in_line_b),
    .in_now_ms (in_now_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_step  (out_step),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic pair_t gray_next(pair_t p);
    case (p)
      2'b00:   return 2'b01;
      2'b01:   return 2'b11;
      2'b11:   return 2'b10;
      default: return 2'b00;
    endcase
  endfunction

  function automatic pair_t gray_prev(pair_t p);
    case (p)
      2'b00:   return 2'b10;
      2'b10:   return 2'b11;
      2'b11:   return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

  function automatic step_t predict_click(pair_t cur, time_t stamp);
    time_t elapsed;
    int delta;
    int sum;
    int mag;
    int lim;
    if (cur == pred_pair) return StepNone;
    if ((cur ^ pred_pair) == 2'b11) begin
      pred_pair = cur;
      return StepNone;
    end
    delta = (cur == gray_next(pred_pair)) ? 1 : -1;
    pred_pair = cur;
    elapsed = stamp - pred_stamp;
    if (elapsed < pred_min_gap) return StepNone;
    if (elapsed < pred_rev_gap &&
        ((pred_accum > 0 && delta < 0) || (pred_accum < 0 && delta > 0)))
      return StepNone;
    pred_stamp = stamp;
    sum = pred_accum + delta;
    lim = (pred_detent > DetentMax) ? DetentMax : pred_detent;
    mag = (sum < 0) ? -sum : sum;
    if (mag >= lim) begin
      pred_accum = 0;
      return (sum > 0) ? StepCw : StepCcw;
    end
    pred_accum = sum;
    return StepNone;
  endfunction

  always @(posedge clk) begin : scoreboard
    step_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_clicks.size() == 0) begin
          $error("unexpected transaction: step %0d", out_step);
          errors++;
        end else begin
          want = expected_clicks.pop_front();
          if (out_step !== want) begin
            $error("step mismatch: expected %0d, actual %0d", want, out_step);
            errors++;
          end
        end
        if (out_step == StepCw) clicks_cw++;
        if (out_step == StepCcw) clicks_ccw++;
      end
      if (in_valid && in_ready)
        expected_clicks.push_back(predict_click({in_line_a, in_line_b}, in_now_ms));
      if (in_valid && !in_ready) input_stall_cycles++;
      if (cfg_we) begin
        case (cfg_index)
          REG_DETENT_STEPS:    pred_detent  = cfg_wdata[4:0];
          REG_MIN_GAP_MS:      pred_min_gap = cfg_wdata;
          REG_REVERSAL_GAP_MS: pred_rev_gap = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle_on ? $urandom_range(0, IdleMax) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_sample(pair_t p, time_t stamp);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, IdleMax) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_line_a <= p[1];
    in_line_b <= p[0];
    in_now_ms <= stamp;
    do @(posedge clk); while (!in_ready);
    tb_pair  = p;
    tb_stamp = stamp;
    samples_sent++;
  endtask

  task automatic rotate(int dir, int unsigned dt);
    send_sample((dir > 0) ? gray_next(tb_pair) : gray_prev(tb_pair), tb_stamp + dt);
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom_range(0, pred_min_gap + 1);
      2:       return $urandom_range(0, pred_rev_gap + 1);
      3:       return $urandom_range(pred_rev_gap, pred_rev_gap + 1);
      4, 5:    return $urandom_range(0, 20);
      6:       return $urandom_range(0, 600);
      default: return $urandom();
    endcase
  endfunction

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_clicks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [7:0] detent, logic [7:0] min_gap, logic [7:0] rev_gap);
    drain_results();
    write_reg(REG_DETENT_STEPS, detent);
    write_reg(REG_MIN_GAP_MS, min_gap);
    write_reg(REG_REVERSAL_GAP_MS, rev_gap);
    settings_used++;
  endtask

  // mostly Gray runs with random timing, some repeats, jumps and random stamps
  task automatic random_walk(int count);
    int target;
    int run;
    int dir;
    int r;
    target = samples_sent + count;
    while (samples_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        dir = $urandom_range(0, 1) ? 1 : -1;
        run = $urandom_range(1, 12);
        repeat (run) begin
          if ($urandom_range(0, 9) == 0) dir = -dir;
          rotate(dir, pick_gap());
        end
      end else if (r < 84) begin
        send_sample(tb_pair, tb_stamp + pick_gap());
      end else if (r < 92) begin
        send_sample(~tb_pair, tb_stamp + pick_gap());
      end else begin
        send_sample(pair_t'($urandom_range(0, 3)), time_t'($urandom()));
      end
    end
  endtask

  task automatic test_directed();
    send_sample(2'b00, 32'd0);
    rotate(1, 0);
    rotate(1, 10);
    rotate(1, 10);
    send_sample(~tb_pair, tb_stamp + 5);
    rotate(1, 10);
    rotate(-1, 2);
    rotate(1, 8);
    rotate(1, 10);
    rotate(-1, 1);
    rotate(-1, 1);
    rotate(-1, 10);
    rotate(-1, 10);
    send_sample(gray_prev(tb_pair), 32'hFFFF_FFF0);
    rotate(-1, 15);
    rotate(-1, 6);
    rotate(1, 0);
    rotate(1, 3);
    send_sample(2'b11, 32'hFFFF_FFFF);
    send_sample(2'b11, 32'h0000_0000);
  endtask

  task automatic test_detent_extremes();
    configure(8'd0, 8'd0, 8'd0);
    random_walk(40);
    configure(8'hFF, 8'd1, 8'd6);
    repeat (20) rotate(1, 10);
    random_walk(40);
    configure(8'd16, 8'd255, 8'd255);
    random_walk(40);
    configure(8'd1, 8'd0, 8'd255);
    write_reg(REG_UNUSED, 8'hA5);
    random_walk(40);
  endtask

  task automatic test_random_settings();
    repeat (9) begin
      configure(8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6)),
                8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4)),
                8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12)));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      random_walk(115);
    end
  endtask

  task automatic test_output_backpressure();
    configure(8'd2, 8'd1, 8'd6);
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    random_walk(40);
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    random_walk(30);
    drain_results();
    random_walk(30);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_detent_extremes();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d samples across %0d register settings: %0d cw and %0d ccw clicks.",
             samples_sent, settings_used, clicks_cw, clicks_ccw);
    $display("Input held off for %0d cycles by result backpressure.", input_stall_cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: quadrature_detent_decoder_core.f
design/qdd_pkg.sv
design/quadrature_detent_decoder_core.sv
dv/quadrature_detent_decoder_core_test.sv
